>>> hdl/rms_pkg.sv
// Shared definitions for the two-key record merge sorter.
// Holds the sequencer state type and the fixed field width; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rms_pkg;

  // width of every key and tag field on the ports
  localparam int unsigned FIELD_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT,
    ST_DRAIN
  } rms_state_e;

endpackage

`default_nettype wire

>>> hdl/rms_store.sv
// Two-bank record store: one write port and two registered read ports.
// Used by the sorter as the ping-pong buffer of the merge passes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rms_store #(
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned DATA_W = 48
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> hdl/two_key_record_merge_sorter.sv
// Two-key stable record sorter: load sequencer, merge compare unit and emitter.
// Depends on rms_pkg and rms_store.
`timescale 1ns / 1ps
`default_nettype none

// Records are loaded one per cycle (start_i while busy_o is low). The request
// with batch_end_i set closes the batch: the block then sorts the stored records
// by (primary, secondary), stable on ties, with a bottom-up merge sort on a
// single compare unit and a two-bank store, and streams them out one per cycle
// on result_valid_o. The receiver cannot stall; every result is shown for one
// cycle only. For a batch of n records the sort takes ceil(log2 n) passes of n
// merge steps, plus one setup step per run pair and one more that finds the
// batch sorted, then the emission; busy_o is high from the closing
// request to the last result. Merging runs at one step per cycle, the most that
// the compare unit and the two store read ports allow. Records that arrive while
// MAX_RECORDS are stored are dropped, and then every result of the batch carries
// overflowed_o.
module two_key_record_merge_sorter #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned KEY_BITS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [15:0] primary_key_i,
  input  wire logic [15:0] secondary_key_i,
  input  wire logic [15:0] record_tag_i,
  input  wire logic        batch_end_i,
  output logic             result_valid_o,
  output logic      [15:0] sorted_primary_o,
  output logic      [15:0] sorted_secondary_o,
  output logic      [15:0] sorted_tag_o,
  output logic             overflowed_o,
  output logic             run_end_o
);

  localparam int unsigned FW = rms_pkg::FIELD_W;
  localparam int unsigned KB = (KEY_BITS < FW) ? KEY_BITS : FW;
  localparam int unsigned RW = 2 * KB + FW;
  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned PW = CW + 2;

  rms_pkg::rms_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          sb_q, sb_d;
  logic [PW-1:0] w_q, w_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] il_q, il_d;
  logic [PW-1:0] ir_q, ir_d;
  logic [PW-1:0] lend_q, lend_d;
  logic [PW-1:0] rend_q, rend_d;
  logic          out_v_q, out_v_d;
  logic          last_q, last_d;

  logic          we;
  logic [AW:0]   waddr, raddr_a, raddr_b;
  logic [RW-1:0] wdata, rd_a, rd_b;

  logic          accept;
  logic          full;
  logic [PW-1:0] n_ext;
  logic          sorted;
  logic [PW-1:0] sum_l, sum_r, lend_c, rend_c;
  logic          l_ok, r_ok, after, take_l;
  logic [PW-1:0] il_n, ir_n;
  logic          pair_done, pass_done, emit_last;

  assign accept = start_i && (state_q == rms_pkg::ST_IDLE);
  assign full   = (count_q == CW'(MAX_RECORDS));
  assign n_ext  = PW'(count_q);
  assign sorted = (w_q >= n_ext);

  // run bounds for the next pair, clipped to the batch size
  assign sum_l  = wp_q + w_q;
  assign sum_r  = wp_q + (w_q << 1);
  assign lend_c = (sum_l < n_ext) ? sum_l : n_ext;
  assign rend_c = (sum_r < n_ext) ? sum_r : n_ext;

  // shared compare unit: take the left head unless it must come after the right
  assign l_ok  = (il_q < lend_q);
  assign r_ok  = (ir_q < rend_q);
  assign after = (rd_a[RW-1 -: KB] > rd_b[RW-1 -: KB]) ||
                 ((rd_a[RW-1 -: KB] == rd_b[RW-1 -: KB]) &&
                  (rd_a[FW+KB-1 -: KB] > rd_b[FW+KB-1 -: KB]));
  assign take_l = l_ok && (!r_ok || !after);
  assign il_n   = il_q + PW'(take_l);
  assign ir_n   = ir_q + PW'(!take_l);

  assign pair_done = (wp_q + PW'(1) == rend_q);
  assign pass_done = pair_done && (rend_q == n_ext);
  assign emit_last = (wp_q + PW'(1) == n_ext);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rms_pkg::ST_IDLE: begin
        if (accept && batch_end_i) begin
          state_d = rms_pkg::ST_SETUP;
        end
      end
      rms_pkg::ST_SETUP: begin
        state_d = sorted ? rms_pkg::ST_EMIT : rms_pkg::ST_MERGE;
      end
      rms_pkg::ST_MERGE: begin
        if (pair_done) begin
          state_d = rms_pkg::ST_SETUP;
        end
      end
      rms_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_d = rms_pkg::ST_DRAIN;
        end
      end
      rms_pkg::ST_DRAIN: begin
        state_d = rms_pkg::ST_IDLE;
      end
      default: begin
        state_d = rms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    sb_d    = sb_q;
    w_d     = w_q;
    wp_d    = wp_q;
    il_d    = il_q;
    ir_d    = ir_q;
    lend_d  = lend_q;
    rend_d  = rend_q;
    out_v_d = 1'b0;
    last_d  = 1'b0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = {primary_key_i[KB-1:0], secondary_key_i[KB-1:0], record_tag_i};
    raddr_a = '0;
    raddr_b = '0;
    unique case (state_q)
      rms_pkg::ST_IDLE: begin
        if (accept) begin
          // load into bank 0; drop when the store is full
          if (!full) begin
            we      = 1'b1;
            waddr   = {1'b0, count_q[AW-1:0]};
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (batch_end_i) begin
            sb_d = 1'b0;
            w_d  = PW'(1);
            wp_d = '0;
          end
        end
      end
      rms_pkg::ST_SETUP: begin
        if (!sorted) begin
          lend_d  = lend_c;
          rend_d  = rend_c;
          il_d    = wp_q;
          ir_d    = lend_c;
          raddr_a = {sb_q, wp_q[AW-1:0]};
          raddr_b = {sb_q, lend_c[AW-1:0]};
        end else begin
          wp_d = '0;
        end
      end
      rms_pkg::ST_MERGE: begin
        we      = 1'b1;
        waddr   = {~sb_q, wp_q[AW-1:0]};
        wdata   = take_l ? rd_a : rd_b;
        il_d    = il_n;
        ir_d    = ir_n;
        raddr_a = {sb_q, il_n[AW-1:0]};
        raddr_b = {sb_q, ir_n[AW-1:0]};
        wp_d    = wp_q + PW'(1);
        if (pass_done) begin
          // swap banks and double the run length
          sb_d = ~sb_q;
          w_d  = w_q << 1;
          wp_d = '0;
        end
      end
      rms_pkg::ST_EMIT: begin
        raddr_a = {sb_q, wp_q[AW-1:0]};
        wp_d    = wp_q + PW'(1);
        out_v_d = 1'b1;
        last_d  = emit_last;
      end
      rms_pkg::ST_DRAIN: begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rms_pkg::ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      out_v_q <= out_v_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q   <= sb_d;
    w_q    <= w_d;
    wp_q   <= wp_d;
    il_q   <= il_d;
    ir_q   <= ir_d;
    lend_q <= lend_d;
    rend_q <= rend_d;
  end

  rms_store #(
    .ADDR_W(AW + 1),
    .DATA_W(RW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign busy_o             = (state_q != rms_pkg::ST_IDLE);
  assign result_valid_o     = out_v_q;
  assign run_end_o          = last_q;
  assign overflowed_o       = ovf_q;
  assign sorted_primary_o   = FW'(rd_a[RW-1 -: KB]);
  assign sorted_secondary_o = FW'(rd_a[FW+KB-1 -: KB]);
  assign sorted_tag_o       = rd_a[FW-1:0];

`ifndef SYNTHESIS
  a_result_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside a sort");

  a_end_marks_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end_o |-> result_valid_o)
    else $error("run end without a result");

  a_end_closes_batch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end_o |=> !result_valid_o)
    else $error("result after the last of the batch");

  a_full_sets_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full) |=> ovf_q)
    else $error("dropped record did not flag overflow");

  a_merge_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rms_pkg::ST_MERGE) |-> (wp_q < n_ext && (l_ok || r_ok)))
    else $error("merge step past the batch or with both runs empty");
`endif

endmodule

`default_nettype wire

>>> tb/rms_checker.sv
// Scoreboard for the two-key record merge sorter: watches the request and result ports,
// predicts each sorted run and compares it with what the block emits.
// Depends on rms_pkg for the field width.
`timescale 1ns / 1ps

module rms_checker #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [rms_pkg::FIELD_W-1:0]  primary_key_i,
  input  logic [rms_pkg::FIELD_W-1:0]  secondary_key_i,
  input  logic [rms_pkg::FIELD_W-1:0]  record_tag_i,
  input  logic                         batch_end_i,
  input  logic                         result_valid_i,
  input  logic [rms_pkg::FIELD_W-1:0]  sorted_primary_i,
  input  logic [rms_pkg::FIELD_W-1:0]  sorted_secondary_i,
  input  logic [rms_pkg::FIELD_W-1:0]  sorted_tag_i,
  input  logic                         overflowed_i,
  input  logic                         run_end_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);

  localparam int unsigned        FIELD_W    = rms_pkg::FIELD_W;
  localparam logic [FIELD_W-1:0] KEY_MASK = FIELD_W'((64'd1 << KEY_BITS) - 64'd1);
  localparam int unsigned        REPORT_MAX = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] primary;
    logic [FIELD_W-1:0] secondary;
    logic [FIELD_W-1:0] tag;
  } record_t;

  typedef struct packed {
    record_t rec;
    logic    overflowed;
    logic    run_end;
  } sorted_entry_t;

  record_t       loaded_records[$];
  bit            records_dropped;
  sorted_entry_t expected_run[$];
  int            mismatches;

  function automatic bit sorts_after(record_t a, record_t b);
    if (a.primary != b.primary) return a.primary > b.primary;
    return a.secondary > b.secondary;
  endfunction

  // Stable insertion sort of the loaded batch; queue one result per stored record.
  function automatic void predict_sorted_run();
    record_t       ordered[$];
    record_t       cur;
    sorted_entry_t entry;
    int            j;
    ordered = loaded_records;
    for (int i = 1; i < ordered.size(); i++) begin
      cur = ordered[i];
      j = i;
      while (j > 0 && sorts_after(ordered[j-1], cur)) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = cur;
    end
    for (int k = 0; k < ordered.size(); k++) begin
      entry.rec        = ordered[k];
      entry.overflowed = records_dropped;
      entry.run_end    = (k == ordered.size() - 1);
      expected_run.push_back(entry);
    end
    loaded_records.delete();
    records_dropped = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_entry_t want;
    record_t       incoming;
    if (!rst_ni) begin
      loaded_records.delete();
      expected_run.delete();
      records_dropped = 1'b0;
      mismatches      = 0;
    end else begin
      // results of the previous batch are checked before a new request lands
      if (result_valid_i) begin
        if (expected_run.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result p=%h s=%h tag=%h ovf=%b end=%b", $time,
                     sorted_primary_i, sorted_secondary_i, sorted_tag_i, overflowed_i,
                     run_end_i);
        end else begin
          want = expected_run.pop_front();
          if (sorted_primary_i !== want.rec.primary ||
              sorted_secondary_i !== want.rec.secondary ||
              sorted_tag_i !== want.rec.tag ||
              overflowed_i !== want.overflowed ||
              run_end_i !== want.run_end) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"%0t: mismatch exp p=%h s=%h tag=%h ovf=%b end=%b, ",
                        "got p=%h s=%h tag=%h ovf=%b end=%b"},
                       $time, want.rec.primary, want.rec.secondary, want.rec.tag,
                       want.overflowed, want.run_end, sorted_primary_i, sorted_secondary_i,
                       sorted_tag_i, overflowed_i, run_end_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (loaded_records.size() < MAX_RECORDS) begin
          incoming.primary   = primary_key_i & KEY_MASK;
          incoming.secondary = secondary_key_i & KEY_MASK;
          incoming.tag       = record_tag_i;
          loaded_records.push_back(incoming);
        end else begin
          records_dropped = 1'b1;
        end
        if (batch_end_i) predict_sorted_run();
      end
    end
    mismatch_count_o = mismatches;
    pending_o        = expected_run.size();
  end

endmodule

>>> tb/two_key_record_merge_sorter_test.sv
// Top of the merge sorter testbench: clock, reset, request stimulus and verdict.
// Depends on rms_pkg, the two_key_record_merge_sorter block and rms_checker.
`timescale 1ns / 1ps

module two_key_record_merge_sorter_test;

  localparam int unsigned FIELD_W      = rms_pkg::FIELD_W;
  localparam int unsigned MAX_RECORDS  = 64;
  localparam int unsigned KEY_BITS     = 16;
  localparam int          RANDOM_ITEMS = 440;
  localparam int          IDLE_LIMIT   = 5000;
  localparam int          TAIL_CYCLES  = 40;

  typedef enum int {
    MIX_TIES,
    MIX_WIDE,
    MIX_PRIMARY_TIES
  } key_mix_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [FIELD_W-1:0] primary_key_i = '0;
  logic [FIELD_W-1:0] secondary_key_i = '0;
  logic [FIELD_W-1:0] record_tag_i = '0;
  logic               batch_end_i = 1'b0;
  logic               busy_o;
  logic               result_valid_o;
  logic [FIELD_W-1:0] sorted_primary_o;
  logic [FIELD_W-1:0] sorted_secondary_o;
  logic [FIELD_W-1:0] sorted_tag_o;
  logic               overflowed_o;
  logic               run_end_o;
  int                 mismatch_count;
  int                 pending;
  int                 idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  two_key_record_merge_sorter #(
    .MAX_RECORDS(MAX_RECORDS),
    .KEY_BITS   (KEY_BITS)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .primary_key_i     (primary_key_i),
    .secondary_key_i   (secondary_key_i),
    .record_tag_i      (record_tag_i),
    .batch_end_i       (batch_end_i),
    .result_valid_o    (result_valid_o),
    .sorted_primary_o  (sorted_primary_o),
    .sorted_secondary_o(sorted_secondary_o),
    .sorted_tag_o      (sorted_tag_o),
    .overflowed_o      (overflowed_o),
    .run_end_o         (run_end_o)
  );

  rms_checker #(
    .MAX_RECORDS(MAX_RECORDS),
    .KEY_BITS   (KEY_BITS)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .primary_key_i     (primary_key_i),
    .secondary_key_i   (secondary_key_i),
    .record_tag_i      (record_tag_i),
    .batch_end_i       (batch_end_i),
    .result_valid_i    (result_valid_o),
    .sorted_primary_i  (sorted_primary_o),
    .sorted_secondary_i(sorted_secondary_o),
    .sorted_tag_i      (sorted_tag_o),
    .overflowed_i      (overflowed_o),
    .run_end_i         (run_end_o),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending)
  );

  // Abort when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("two_key_record_merge_sorter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Leaves start_i high on return so back-to-back requests need no toggle.
  task automatic send_record(input logic [FIELD_W-1:0] pk, input logic [FIELD_W-1:0] sk,
                             input logic [FIELD_W-1:0] tag, input logic last,
                             input bit burst);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    primary_key_i   <= pk;
    secondary_key_i <= sk;
    record_tag_i    <= tag;
    batch_end_i     <= last;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    int                 sent;
    int                 batch;
    int                 batch_size;
    int                 roll;
    bit                 burst;
    key_mix_e           mix;
    logic [FIELD_W-1:0] pk;
    logic [FIELD_W-1:0] sk;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-record batch
    send_record(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    // key extremes
    send_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    send_record(16'h0000, 16'hFFFF, 16'h1234, 1'b0, 1'b1);
    send_record(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_record(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
    // equal key pairs must keep load order
    send_record(16'h0005, 16'h0007, 16'h0001, 1'b0, 1'b1);
    send_record(16'h0005, 16'h0007, 16'h0002, 1'b0, 1'b1);
    send_record(16'h0003, 16'h0009, 16'h0003, 1'b0, 1'b1);
    send_record(16'h0005, 16'h0007, 16'h0004, 1'b0, 1'b0);
    send_record(16'h0005, 16'h0002, 16'h0005, 1'b0, 1'b0);
    send_record(16'h0003, 16'h0009, 16'h0006, 1'b1, 1'b0);
    // fully reversed input
    for (int i = 0; i < 8; i++)
      send_record(FIELD_W'((7 - i) << 13), FIELD_W'(i * 3), FIELD_W'(i), i == 7, 1'b1);
    send_record(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0);
    send_record(16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0);

    // Random batches; the first overflows the store on its closing request and the
    // second fills it exactly.
    sent  = 0;
    batch = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (batch == 0) batch_size = MAX_RECORDS + 1;
      else if (batch == 1) batch_size = MAX_RECORDS;
      else if (roll < 4) batch_size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
      else if (roll < 12) batch_size = $urandom_range(17, MAX_RECORDS);
      else batch_size = $urandom_range(1, 16);
      mix   = key_mix_e'($urandom_range(0, 2));
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < batch_size; k++) begin
        case (mix)
          MIX_TIES: begin
            pk = FIELD_W'($urandom_range(0, 3));
            sk = FIELD_W'($urandom_range(0, 3));
          end
          MIX_PRIMARY_TIES: begin
            pk = FIELD_W'($urandom_range(0, 7));
            sk = FIELD_W'($urandom);
          end
          default: begin
            pk = FIELD_W'($urandom);
            sk = FIELD_W'($urandom);
          end
        endcase
        send_record(pk, sk, FIELD_W'($urandom), k == batch_size - 1, burst);
      end
      sent += batch_size;
      batch++;
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("two_key_record_merge_sorter test passed");
    end else begin
      $display("two_key_record_merge_sorter test failed");
    end
    $finish;
  end

endmodule

>>> two_key_record_merge_sorter.f
hdl/rms_pkg.sv
hdl/rms_store.sv
hdl/two_key_record_merge_sorter.sv
tb/rms_checker.sv
tb/two_key_record_merge_sorter_test.sv
